### sv/bss_pkg.sv
// Shared types and constants for the byte string sorter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

  // Buffer capacity in bytes; allowed range is 2 to 64.
  localparam int unsigned MaxLen = 32;
  localparam int unsigned IdxW   = $clog2(MaxLen);
  localparam int unsigned CntW   = $clog2(MaxLen + 1);

  // Queue between the front and the back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    OP_STORE,
    OP_DROP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       last;
  } cmd_t;

endpackage

`default_nettype wire

### sv/bss_front.sv
// Front of the byte string sorter: accepts bytes and classifies store or drop.
// Depends on bss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bss_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    char_in_i,
  input  wire logic          last_in_i,
  output logic               push_o,
  output bss_pkg::cmd_t      cmd_o,
  input  wire logic          full_i
);
  import bss_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            has_room;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign has_room   = cnt_q < CntW'(MaxLen);

  always_comb begin
    cmd_o.op   = has_room ? OP_STORE : OP_DROP;
    cmd_o.data = char_in_i;
    cmd_o.last = last_in_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (last_in_i) begin
        cnt_d = '0;
      end else if (has_room) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### sv/bss_fifo.sv
// Short command queue between the front and the back of the sorter.
// Depends on bss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bss_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bss_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output bss_pkg::cmd_t      cmd_o,
  output logic               valid_o
);
  import bss_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/bss_back.sv
// Back of the sorter: byte buffer, odd-even transposition sort, result register.
// Depends on bss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bss_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bss_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         char_out_o,
  output logic               last_out_o,
  output logic               truncated_o
);
  import bss_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [7:0]      store_q [MaxLen];
  logic [7:0]      sort_d  [MaxLen];
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] pass_q;
  logic            ovf_q;
  logic            out_valid_q;
  logic            load_out;
  logic            sort_done;

  assign cmd_pop_o   = (state_q == ST_LOAD) && cmd_valid_i;
  assign load_out    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign sort_done   = (CntW'(pass_q) + CntW'(1)) >= cnt_q;
  assign out_valid_o = out_valid_q;

  // One transposition pass: even or odd pairs, only inside the filled range.
  always_comb begin
    sort_d = store_q;
    for (int k = 0; k < MaxLen - 1; k++) begin
      if ((k[0] == pass_q[0]) && (CntW'(k + 1) < cnt_q) &&
          (store_q[k] > store_q[k + 1])) begin
        sort_d[k]     = store_q[k + 1];
        sort_d[k + 1] = store_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && (cmd_i.op == OP_STORE)) begin
      store_q[cnt_q[IdxW-1:0]] <= cmd_i.data;
    end else if (state_q == ST_SORT) begin
      store_q <= sort_d;
    end else if (load_out) begin
      for (int k = 0; k < MaxLen - 1; k++) begin
        store_q[k] <= store_q[k + 1];
      end
    end
    if (load_out) begin
      char_out_o  <= store_q[0];
      last_out_o  <= cnt_q == CntW'(1);
      truncated_o <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      pass_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (cmd_pop_o) begin
            if (cmd_i.op == OP_STORE) begin
              cnt_q <= cnt_q + CntW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (cmd_i.last) begin
              pass_q  <= '0;
              state_q <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          pass_q <= pass_q + IdxW'(1);
          if (sort_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            cnt_q <= cnt_q - CntW'(1);
            if (cnt_q == CntW'(1)) begin
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_store_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && (cmd_i.op == OP_STORE)) |-> (cnt_q < CntW'(MaxLen)))
    else $error("store command arrived with a full buffer");

  a_sort_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT) |-> (cnt_q != '0))
    else $error("sort started on an empty buffer");

  a_emit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (cnt_q == CntW'(1))) |=> ((state_q == ST_LOAD) && (cnt_q == '0) && !ovf_q))
    else $error("string did not close after its final result");
`endif

endmodule

`default_nettype wire

### sv/byte_string_sorter.sv
// Byte string sorter top level: front, command queue and sort back end.
// Depends on bss_pkg, bss_front, bss_fifo and bss_back.
//
// A string enters one byte per transaction on the input channel, its final
// byte flagged by last_in_i, and leaves sorted in ascending unsigned order,
// one byte per transaction, the final one flagged by last_out_o. Up to
// MaxLen (32) bytes are kept; further bytes are dropped and every result of
// that string carries truncated_o. Bytes load at one per cycle, while the back
// end is loading, through a four-entry command queue. When the final byte
// reaches the back end, an odd-even transposition sort over the register row
// of the buffer runs one pass per cycle, then results leave at one per cycle
// while out_stall_i is low. The front keeps taking bytes of the next string
// into the queue while sorting and emission run, and stalls only once the
// queue is full.
`timescale 1ns / 1ps
`default_nettype none

module byte_string_sorter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_in_i,
  input  wire logic       last_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      char_out_o,
  output logic            last_out_o,
  output logic            truncated_o
);
  import bss_pkg::*;

  // Classified commands from the front into the queue.
  cmd_t push_cmd;
  logic push;
  logic full;

  // Queue head into the back end.
  cmd_t head_cmd;
  logic head_valid;
  logic pop;

  // Front: count bytes of the current string, mark store or drop.
  bss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_in_i  (char_in_i),
    .last_in_i  (last_in_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  // Queue: decouple byte intake from sorting and emission.
  bss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .valid_o (head_valid)
  );

  // Back: buffer, sort, hold each result in the output register.
  bss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (head_valid),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .last_out_o  (last_out_o),
    .truncated_o (truncated_o)
  );

endmodule

`default_nettype wire
